[design/b32enc_pkg.sv]
// shared types, constants and a helper function for the base32 stream encoder
package b32enc_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [6:0] PAD_CHAR   = 7'h3D;
    localparam logic [6:0] UPPER_BASE = 7'h41;
    localparam logic [6:0] DIGIT_BASE = 7'h18;
    localparam logic [4:0] NUM_LETTERS = 5'd26;
    localparam logic [3:0] GROUP_CHARS = 4'd8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_final;
    } in_item_t;

    typedef struct packed {
        logic [6:0] out_char;
        logic       last_char;
    } out_item_t;

    // one queued transaction: up to three symbol indexes plus padding
    typedef struct packed {
        logic [2:0][4:0] sym;
        logic [1:0]      num_sym;
        logic [3:0]      num_total;
        logic            is_final;
    } job_t;

    function automatic logic [6:0] sym_to_ascii(input logic [4:0] sym);
        logic [6:0] code;
        if (sym < NUM_LETTERS)
        begin
            code = UPPER_BASE + 7'(sym);
        end
        else
        begin
            code = DIGIT_BASE + 7'(sym);
        end
        return code;
    endfunction

endpackage

[design/b32enc_front.sv]
// front end: takes bytes, slices 5-bit symbols and works out padding
module b32enc_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  b32enc_pkg::in_item_t byte_item,
    input  logic                q_full,
    output logic                push,
    output b32enc_pkg::job_t    push_job
);

    logic [3:0]  left_reg, left_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [2:0]  group_reg, group_next;

    logic [11:0] acc;
    logic [11:0] aligned;
    logic [2:0]  shift;
    logic [3:0]  bits;
    logic        two;
    logic [2:0]  rem;
    logic [4:0]  flush_sym;
    logic        do_flush;
    logic [2:0]  group_data;
    logic [2:0]  group_flush;
    logic [2:0]  pads;
    logic [3:0]  sum;
    logic [3:0]  mask;

    assign byte_stall = q_full;
    assign push       = byte_valid && !q_full;

    always_comb
    begin
        acc        = {left_reg, byte_item.data_byte};
        shift      = 3'd4 - cnt_reg;
        aligned    = 12'(acc << shift);
        bits       = 4'(cnt_reg) + 4'd8;
        two        = (bits >= 4'd10);
        rem        = two ? 3'(bits - 4'd10) : 3'(bits - 4'd5);
        flush_sym  = two ? {aligned[1:0], 3'b000} : aligned[6:2];
        do_flush   = byte_item.is_final && (rem != 3'd0);
        group_data = group_reg + (two ? 3'd2 : 3'd1);
        group_flush = group_data + (do_flush ? 3'd1 : 3'd0);
        pads       = byte_item.is_final ? 3'(3'd0 - group_flush) : 3'd0;
        sum        = (two ? 4'd2 : 4'd1) + (do_flush ? 4'd1 : 4'd0) + 4'(pads);
        mask       = 4'((5'd1 << rem) - 5'd1);

        push_job.sym[0]   = aligned[11:7];
        push_job.sym[1]   = two ? aligned[6:2] : flush_sym;
        push_job.sym[2]   = flush_sym;
        push_job.num_sym  = (two ? 2'd2 : 2'd1) + (do_flush ? 2'd1 : 2'd0);
        push_job.num_total = (sum > b32enc_pkg::GROUP_CHARS) ? b32enc_pkg::GROUP_CHARS : sum;
        push_job.is_final = byte_item.is_final;

        left_next  = left_reg;
        cnt_next   = cnt_reg;
        group_next = group_reg;
        if (push)
        begin
            if (byte_item.is_final)
            begin
                left_next  = 4'd0;
                cnt_next   = 3'd0;
                group_next = 3'd0;
            end
            else
            begin
                left_next  = byte_item.data_byte[3:0] & mask;
                cnt_next   = rem;
                group_next = group_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= 4'd0;
            cnt_reg   <= 3'd0;
            group_reg <= 3'd0;
        end
        else
        begin
            left_reg  <= left_next;
            cnt_reg   <= cnt_next;
            group_reg <= group_next;
        end
    end

endmodule

[design/b32enc_queue.sv]
// small queue of transactions between front and back end
module b32enc_queue
#(
    parameter int DEPTH = b32enc_pkg::QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  b32enc_pkg::job_t push_job,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output b32enc_pkg::job_t head_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    b32enc_pkg::job_t mem [DEPTH];

    logic [AW-1:0] wr_reg, wr_next;
    logic [AW-1:0] rd_reg, rd_next;
    logic [AW:0]   count_reg, count_next;

    assign full       = (count_reg == (AW+1)'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem[rd_reg];

    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_next = (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule

[design/b32enc_back.sv]
// back end: walks each transaction and emits one character per cycle while char_stall is low
module b32enc_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  b32enc_pkg::job_t      head_job,
    output logic                  pop,
    output logic                  char_valid,
    input  logic                  char_stall,
    output b32enc_pkg::out_item_t char_item
);

    logic [2:0]  idx_reg, idx_next;
    logic        valid_reg, valid_next;
    b32enc_pkg::out_item_t item_reg, item_next;

    logic        load;
    logic        at_end;
    logic [4:0]  sym;

    assign char_valid = valid_reg;
    assign char_item  = item_reg;

    always_comb
    begin
        load   = head_valid && (!valid_reg || !char_stall);
        at_end = ({1'b0, idx_reg} == head_job.num_total - 4'd1);
        pop    = load && at_end;

        unique case (idx_reg)
            3'd0:    sym = head_job.sym[0];
            3'd1:    sym = head_job.sym[1];
            default: sym = head_job.sym[2];
        endcase

        idx_next   = idx_reg;
        valid_next = valid_reg;
        item_next  = item_reg;
        if (load)
        begin
            valid_next = 1'b1;
            item_next.out_char  = ({1'b0, idx_reg} < 4'(head_job.num_sym))
                                  ? b32enc_pkg::sym_to_ascii(sym) : b32enc_pkg::PAD_CHAR;
            item_next.last_char = head_job.is_final && at_end;
            idx_next = at_end ? 3'd0 : idx_reg + 3'd1;
        end
        else if (!char_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

[design/base32_stream_encoder.sv]
// top level of the streaming base32 encoder
// the first character of a byte passes through a queue slot and then the character output register
// throughput: one character per cycle while char_stall is low; a byte yields 1 or 2 characters, a final byte up to 8
// the character output register sets the rate; bytes are taken while the queue has room
// reset clears the leftover bits, group count, queue pointers and the output valid flag
module base32_stream_encoder
#(
    parameter int QUEUE_DEPTH = b32enc_pkg::QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_stall,
    input  b32enc_pkg::in_item_t  byte_item,
    output logic                  char_valid,
    input  logic                  char_stall,
    output b32enc_pkg::out_item_t char_item
);

    logic             q_full;
    logic             push;
    logic             pop;
    logic             head_valid;
    b32enc_pkg::job_t push_job;
    b32enc_pkg::job_t head_job;

    b32enc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .q_full     (q_full),
        .push       (push),
        .push_job   (push_job)
    );

    b32enc_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    b32enc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item)
    );

endmodule

[tb/base32_stream_encoder_test.sv]
// self-checking testbench for the streaming base32 encoder with a built-in character predictor
module base32_stream_encoder_test;

    localparam int CLK_HALF = 10;
    localparam int LONG_HOLD = 300;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_CHARS = 8;
    localparam int GROUP_LEN = 8;
    localparam logic [6:0] LETTER_BASE = 7'h41;
    localparam logic [6:0] DIGIT_TWO = 7'h32;

    logic                  clk;
    logic                  rst_n;
    logic                  byte_valid;
    logic                  byte_stall;
    b32enc_pkg::in_item_t  byte_item;
    logic                  char_valid;
    logic                  char_stall;
    b32enc_pkg::out_item_t char_item;

    // predictor state
    logic [3:0] leftover_bits = '0;
    int unsigned leftover_count = 0;
    int unsigned chars_in_group = 0;

    b32enc_pkg::out_item_t expected_chars[$];
    b32enc_pkg::out_item_t step_chars[$];
    b32enc_pkg::out_item_t want_char;

    int  mismatches = 0;
    int  quiet_cycles = 0;
    bit  idle_bursts = 1'b0;
    bit  hold_request = 1'b0;

    base32_stream_encoder dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    function automatic logic [6:0] symbol_char(input logic [4:0] sym);
        if (sym < 5'd26)
        begin
            return LETTER_BASE + 7'(sym);
        end
        return DIGIT_TWO + 7'(sym - 5'd26);
    endfunction

    function automatic void add_char(input logic [6:0] code);
        if (step_chars.size() < MAX_CHARS)
        begin
            step_chars.push_back('{out_char: code, last_char: 1'b0});
            chars_in_group = (chars_in_group + 1) % GROUP_LEN;
        end
    endfunction

    // expected characters for one accepted byte
    function automatic void encode_byte(input logic [7:0] data, input logic fin);
        logic [11:0] acc;
        int unsigned cnt;
        int unsigned bits;
        b32enc_pkg::out_item_t item;
        cnt = (leftover_count > 4) ? 4 : leftover_count;
        acc = {leftover_bits, data} & ((12'd1 << (cnt + 8)) - 12'd1);
        bits = cnt + 8;
        step_chars.delete();
        while (bits >= 5)
        begin
            add_char(symbol_char(5'((acc >> (bits - 5)) & 12'h1F)));
            bits = bits - 5;
        end
        acc = acc & ((12'd1 << bits) - 12'd1);
        if (fin)
        begin
            if (bits > 0)
            begin
                add_char(symbol_char(5'((acc << (5 - bits)) & 12'h1F)));
            end
            while (chars_in_group != 0 && step_chars.size() < MAX_CHARS)
            begin
                add_char(b32enc_pkg::PAD_CHAR);
            end
            leftover_bits = '0;
            leftover_count = 0;
            chars_in_group = 0;
        end
        else
        begin
            leftover_bits = acc[3:0];
            leftover_count = bits;
        end
        for (int i = 0; i < step_chars.size(); i++)
        begin
            item = step_chars[i];
            item.last_char = fin && (i == step_chars.size() - 1);
            expected_chars.push_back(item);
        end
    endfunction

    // offer one byte and hold it until the transaction completes
    task automatic send_byte(input logic [7:0] data, input logic fin);
        byte_item <= '{data_byte: data, is_final: fin};
        byte_valid <= 1'b1;
        @(posedge clk);
        while (byte_stall)
        begin
            @(posedge clk);
        end
        encode_byte(data, fin);
    endtask

    task automatic maybe_pause_sender();
        if (idle_bursts && $urandom_range(0, 3) == 0)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic wait_drain();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
        begin
            send_byte(text[i], i == text.len() - 1);
            maybe_pause_sender();
        end
    endtask

    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic test_single_byte_extremes();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        wait_drain();
    endtask

    // every leftover phase and every padding length
    task automatic test_padding_lengths();
        send_text("f");
        send_text("fo");
        send_text("foo");
        send_text("foob");
        send_text("fooba");
        send_text("foobar");
        wait_drain();
    endtask

    task automatic test_output_backpressure();
        hold_request = 1'b1;
        for (int i = 0; i < 20; i++)
        begin
            send_byte(8'($urandom_range(0, 255)), i == 19);
        end
        wait_drain();
    endtask

    task automatic test_random_messages(input int byte_budget);
        int sent;
        int len;
        sent = 0;
        while (sent < byte_budget)
        begin
            idle_bursts = ($urandom_range(0, 2) != 0);
            len = $urandom_range(1, 10);
            for (int i = 0; i < len; i++)
            begin
                send_byte(random_byte(), i == len - 1);
                sent++;
                if (i != len - 1 && $urandom_range(0, 15) == 0)
                begin
                    wait_drain();
                end
                else
                begin
                    maybe_pause_sender();
                end
            end
        end
        wait_drain();
    endtask

    task automatic test_steady_stream();
        idle_bursts = 1'b0;
        for (int i = 0; i < 20; i++)
        begin
            send_byte(random_byte(), (i % 7 == 6) || (i == 19));
        end
        wait_drain();
    endtask

    // receiver stall: random bursts, plus one long hold on request
    initial
    begin
        char_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                char_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                char_stall <= 1'b0;
            end
            else if (idle_bursts && $urandom_range(0, 7) == 0)
            begin
                char_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                char_stall <= 1'b0;
            end
        end
    end

    // compare each character transaction with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && char_valid && !char_stall)
        begin
            if (expected_chars.size() == 0)
            begin
                $error("unexpected character transaction %h", char_item);
                mismatches++;
            end
            else
            begin
                want_char = expected_chars.pop_front();
                if (char_item.out_char !== want_char.out_char)
                begin
                    $error("out_char expected %h actual %h",
                           want_char.out_char, char_item.out_char);
                    mismatches++;
                end
                if (char_item.last_char !== want_char.last_char)
                begin
                    $error("last_char expected %b actual %b",
                           want_char.last_char, char_item.last_char);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (byte_valid && !byte_stall) || (char_valid && !char_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        byte_valid = 1'b0;
        byte_item = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_single_byte_extremes();
        test_padding_lengths();
        idle_bursts = 1'b1;
        test_output_backpressure();
        test_random_messages(70);
        test_steady_stream();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
